@@ hdl/wsd_pkg.sv @@
`default_nettype none

package wsd_pkg;

    // Length codes of the second header byte that announce an extended length.
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Index of the last extended length byte for each form, counted from zero.
    localparam logic [2:0] EXT_LAST_16 = 3'd1;
    localparam logic [2:0] EXT_LAST_64 = 3'd7;

    // Index of the last mask key byte.
    localparam logic [2:0] KEY_LAST = 3'd3;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_byte;
        logic       fin_flag;
        logic [3:0] frame_opcode;
        logic       was_masked;
        logic       last_of_frame;
    } t_result;

    // Result offered by the parser in the cycle it consumes a byte.
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_push;

endpackage

`default_nettype wire

@@ hdl/wsd_parser.sv @@
`default_nettype none

module wsd_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [7:0]        i_byte,
    output wsd_pkg::t_res_push     o_push
);

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]  r_phase,  n_phase;
    logic [2:0]  r_hcnt,   n_hcnt;
    logic [63:0] r_len,    n_len;
    logic [31:0] r_key,    n_key;
    logic [1:0]  r_mpos,   n_mpos;
    logic        r_fin,    n_fin;
    logic [3:0]  r_opc,    n_opc;
    logic        r_masked, n_masked;
    logic        r_long,   n_long;

    logic        len_done;
    logic [63:0] done_len;
    logic [6:0]  len_code;
    logic [2:0]  ext_last;
    logic [7:0]  key_byte;
    logic        emit;
    logic        emit_has;
    logic        emit_last;
    logic [7:0]  emit_byte;

    always_comb begin
        n_phase   = r_phase;
        n_hcnt    = r_hcnt;
        n_len     = r_len;
        n_key     = r_key;
        n_mpos    = r_mpos;
        n_fin     = r_fin;
        n_opc     = r_opc;
        n_masked  = r_masked;
        n_long    = r_long;
        len_done  = 1'b0;
        done_len  = r_len;
        len_code  = i_byte[6:0];
        ext_last  = r_long ? wsd_pkg::EXT_LAST_64 : wsd_pkg::EXT_LAST_16;
        key_byte  = 8'd0;
        emit      = 1'b0;
        emit_has  = 1'b0;
        emit_last = 1'b1;
        emit_byte = 8'd0;

        unique case (r_phase)
            PH_HDR1: begin
                n_masked = i_byte[7];
                n_hcnt   = 3'd0;
                if (len_code == wsd_pkg::LEN_CODE_16 || len_code == wsd_pkg::LEN_CODE_64) begin
                    n_long  = (len_code == wsd_pkg::LEN_CODE_64);
                    n_len   = 64'd0;
                    n_phase = PH_EXTLEN;
                end else begin
                    n_len    = {57'd0, len_code};
                    len_done = 1'b1;
                    done_len = {57'd0, len_code};
                end
            end
            PH_EXTLEN: begin
                n_len = {r_len[55:0], i_byte};
                if (r_hcnt >= ext_last) begin
                    len_done = 1'b1;
                    done_len = {r_len[55:0], i_byte};
                end else begin
                    n_hcnt = r_hcnt + 3'd1;
                end
            end
            PH_MASK: begin
                n_key = {r_key[23:0], i_byte};
                if (r_hcnt >= wsd_pkg::KEY_LAST) begin
                    n_hcnt = 3'd0;
                    n_mpos = 2'd0;
                    if (r_len == 64'd0) begin
                        n_phase = PH_HDR0;
                        emit    = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_hcnt = r_hcnt + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                if (r_masked) begin
                    case (r_mpos)
                        2'd0:    key_byte = r_key[31:24];
                        2'd1:    key_byte = r_key[23:16];
                        2'd2:    key_byte = r_key[15:8];
                        default: key_byte = r_key[7:0];
                    endcase
                end
                n_mpos    = r_mpos + 2'd1;
                n_len     = r_len - 64'd1;
                emit      = 1'b1;
                emit_has  = 1'b1;
                emit_byte = i_byte ^ key_byte;
                emit_last = (r_len == 64'd1);
                if (r_len == 64'd1) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                // First header byte; unused phase codes land here as well.
                n_fin   = i_byte[7];
                n_opc   = i_byte[3:0];
                n_phase = PH_HDR1;
            end
        endcase

        // The length is complete: a masked frame reads its key next, otherwise
        // the payload starts or an empty frame is closed with a marker.
        if (len_done) begin
            n_hcnt = 3'd0;
            if (n_masked) begin
                n_phase = PH_MASK;
            end else begin
                n_mpos = 2'd0;
                if (done_len == 64'd0) begin
                    n_phase = PH_HDR0;
                    emit    = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    always_comb begin
        o_push.valid             = i_take && emit;
        o_push.res.payload_byte  = emit_byte;
        o_push.res.has_byte      = emit_has;
        o_push.res.fin_flag      = n_fin;
        o_push.res.frame_opcode  = n_opc;
        o_push.res.was_masked    = n_masked;
        o_push.res.last_of_frame = emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_hcnt   <= 3'd0;
            r_len    <= 64'd0;
            r_key    <= 32'd0;
            r_mpos   <= 2'd0;
            r_fin    <= 1'b0;
            r_opc    <= 4'd0;
            r_masked <= 1'b0;
            r_long   <= 1'b0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_len    <= n_len;
            r_key    <= n_key;
            r_mpos   <= n_mpos;
            r_fin    <= n_fin;
            r_opc    <= n_opc;
            r_masked <= n_masked;
            r_long   <= n_long;
        end
    end

    // An empty-frame marker always closes its frame and carries a zero byte.
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid && !o_push.res.has_byte |->
            o_push.res.last_of_frame && o_push.res.payload_byte == 8'd0)
        else $error("empty-frame marker malformed");

    // The final payload byte returns the parser to the first header byte.
    a_payload_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && r_phase == PH_PAYLOAD && r_len == 64'd1 |=> r_phase == PH_HDR0)
        else $error("parser did not return to header after last payload byte");

    // A payload byte is only ever produced from the payload phase.
    a_byte_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid && o_push.res.has_byte |-> r_phase == PH_PAYLOAD)
        else $error("payload byte produced outside payload phase");

endmodule

`default_nettype wire

@@ hdl/wsd_out_reg.sv @@
`default_nettype none

module wsd_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wsd_pkg::t_res_push i_push,
    input  wire logic              i_stall,
    output logic                   o_ready,
    output logic                   o_valid,
    output wsd_pkg::t_result       o_res
);

    logic             r_valid;
    wsd_pkg::t_result r_res;

    // The register can be reloaded when it is empty or its transaction completes.
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_push.valid) begin
            r_res <= i_push.res;
        end
    end

endmodule

`default_nettype wire

@@ hdl/websocket_frame_deframer_core.sv @@
`default_nettype none

// WebSocket frame deframer, base framing only.
// The input channel (i_valid, o_stall, i_in_byte) carries the raw frame stream,
// one byte per transaction, frames following each other without gaps.
// The output channel (o_valid, i_stall and the o_* result fields) carries one
// transaction per payload byte, unmasked, with the FIN bit, opcode and mask
// flag of the frame it belongs to; the last byte of a frame is flagged.
// A frame of zero length gives a single marker transaction with no byte.
// Header, extended length and mask key bytes give no transaction.
// Each accepted byte is registered, then its result is registered for output.
// Throughput is one byte per cycle: the input register, the parser and the
// result register form a two-stage pipeline that advances every cycle the
// result register is free or being emptied.
// When the receiver stalls, the result register holds its transaction, the
// input register keeps the next byte and o_stall rises once that is full.
// A synchronous reset (i_rst_n low) empties both registers and returns the
// parser to expecting the first header byte of a new frame.

module websocket_frame_deframer_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_payload_byte,
    output logic            o_has_byte,
    output logic            o_fin_flag,
    output logic [3:0]      o_frame_opcode,
    output logic            o_was_masked,
    output logic            o_last_of_frame
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                out_ready;
    logic                take;
    wsd_pkg::t_res_push  push;
    wsd_pkg::t_result    res;

    // The byte in the input register is consumed whenever the result register
    // can take whatever the parser produces for it.
    assign take    = r_in_valid && out_ready;
    assign o_stall = r_in_valid && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    wsd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    wsd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_stall),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .o_res   (res)
    );

    assign o_payload_byte  = res.payload_byte;
    assign o_has_byte      = res.has_byte;
    assign o_fin_flag      = res.fin_flag;
    assign o_frame_opcode  = res.frame_opcode;
    assign o_was_masked    = res.was_masked;
    assign o_last_of_frame = res.last_of_frame;

    // Input back-pressure only appears while a finished result is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // A byte in the input register that was not consumed is still there.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !take |=> r_in_valid && $stable(r_in_byte))
        else $error("input register lost a byte");

endmodule

`default_nettype wire

@@ sim/tb_websocket_frame_deframer_core.sv @@
`default_nettype none

module tb_websocket_frame_deframer_core;

    // Where the parser stands inside the current frame.
    typedef enum logic [2:0] {
        HDR_FIRST,
        HDR_SECOND,
        EXT_LENGTH,
        MASK_KEY,
        PAYLOAD
    } t_frame_phase;

    // Number of random stream bytes and the edge count waited out at the end.
    localparam int unsigned RANDOM_BYTES   = 1500;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned REPORT_LIMIT   = 10;

    // Clock, reset and the two channels. Every input starts at a known value.
    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_payload_byte;
    logic       o_has_byte;
    logic       o_fin_flag;
    logic [3:0] o_frame_opcode;
    logic       o_was_masked;
    logic       o_last_of_frame;

    // When idling_on is low neither side inserts idle cycles.
    logic        idling_on = 1'b1;
    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;

    // Results the deframer owes us, oldest first.
    wsd_pkg::t_result expected_results[$];

    // Our own copy of the parser state, updated once per accepted byte.
    t_frame_phase phase       = HDR_FIRST;
    logic [2:0]   hdr_count   = 3'd0;
    logic [63:0]  bytes_left  = 64'd0;
    logic [31:0]  mask_word   = 32'd0;
    logic [1:0]   key_pos     = 2'd0;
    logic         cur_fin     = 1'b0;
    logic [3:0]   cur_opcode  = 4'd0;
    logic         cur_masked  = 1'b0;
    logic         long_form   = 1'b0;

    websocket_frame_deframer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_payload_byte (o_payload_byte),
        .o_has_byte     (o_has_byte),
        .o_fin_flag     (o_fin_flag),
        .o_frame_opcode (o_frame_opcode),
        .o_was_masked   (o_was_masked),
        .o_last_of_frame(o_last_of_frame)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Queue one expected transaction tagged with the header of the current frame.
    function automatic void expect_result(input logic [7:0] data, input logic has,
                                          input logic last);
        wsd_pkg::t_result r;
        r.payload_byte  = data;
        r.has_byte      = has;
        r.fin_flag      = cur_fin;
        r.frame_opcode  = cur_opcode;
        r.was_masked    = cur_masked;
        r.last_of_frame = last;
        expected_results.push_back(r);
    endfunction

    // The payload length is now complete. A masked frame still has its key to
    // read; an unmasked frame of zero length ends right here with a marker.
    function automatic void length_complete();
        hdr_count = 3'd0;
        if (cur_masked) begin
            mask_word = 32'd0;
            phase = MASK_KEY;
        end else begin
            key_pos = 2'd0;
            if (bytes_left == 64'd0) begin
                phase = HDR_FIRST;
                expect_result(8'h00, 1'b0, 1'b1);
            end else begin
                phase = PAYLOAD;
            end
        end
    endfunction

    // Advance the parser copy by one accepted stream byte.
    function automatic void deframe_byte(input logic [7:0] b);
        logic [7:0]  key_byte;
        logic [2:0]  ext_last;
        int unsigned shift;
        case (phase)
            HDR_SECOND: begin
                cur_masked = b[7];
                hdr_count = 3'd0;
                if (b[6:0] == wsd_pkg::LEN_CODE_16 || b[6:0] == wsd_pkg::LEN_CODE_64) begin
                    long_form = (b[6:0] == wsd_pkg::LEN_CODE_64);
                    bytes_left = 64'd0;
                    phase = EXT_LENGTH;
                end else begin
                    bytes_left = 64'(b[6:0]);
                    length_complete();
                end
            end
            EXT_LENGTH: begin
                // Extended lengths are big-endian and taken as given, even when
                // a shorter form would have fit or the top bit is set.
                bytes_left = {bytes_left[55:0], b};
                ext_last = long_form ? wsd_pkg::EXT_LAST_64 : wsd_pkg::EXT_LAST_16;
                if (hdr_count >= ext_last) begin
                    length_complete();
                end else begin
                    hdr_count = hdr_count + 3'd1;
                end
            end
            MASK_KEY: begin
                mask_word = {mask_word[23:0], b};
                if (hdr_count >= wsd_pkg::KEY_LAST) begin
                    hdr_count = 3'd0;
                    key_pos = 2'd0;
                    if (bytes_left == 64'd0) begin
                        phase = HDR_FIRST;
                        expect_result(8'h00, 1'b0, 1'b1);
                    end else begin
                        phase = PAYLOAD;
                    end
                end else begin
                    hdr_count = hdr_count + 3'd1;
                end
            end
            PAYLOAD: begin
                // The first key byte received applies to payload position zero.
                key_byte = 8'h00;
                if (cur_masked) begin
                    shift = 8 * (3 - int'(key_pos));
                    key_byte = 8'(mask_word >> shift);
                end
                key_pos = key_pos + 2'd1;
                bytes_left = bytes_left - 64'd1;
                if (bytes_left == 64'd0) begin
                    phase = HDR_FIRST;
                    expect_result(b ^ key_byte, 1'b1, 1'b1);
                end else begin
                    expect_result(b ^ key_byte, 1'b1, 1'b0);
                end
            end
            default: begin
                // The reserved bits of the first header byte are dropped.
                cur_fin = b[7];
                cur_opcode = b[3:0];
                phase = HDR_SECOND;
            end
        endcase
    endfunction

    // Offer one byte and return at the edge that accepts it. Valid stays high
    // afterwards so that back-to-back bytes need no second assignment in a step.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // Stop offering bytes and wait until every owed transaction has arrived.
    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // One frame with a random header, mostly short payloads and now and then
    // an extended length, masked or not.
    task automatic send_random_frame();
        logic [7:0]  first_byte;
        logic        use_mask;
        logic [6:0]  code;
        int unsigned len;
        int unsigned pick;
        first_byte = 8'($urandom);
        use_mask = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            len = 0;
        end else if (pick < 80) begin
            len = $urandom_range(1, 20);
        end else if (pick < 90) begin
            len = $urandom_range(21, 125);
        end else begin
            len = $urandom_range(0, 300);
        end
        if (pick >= 96) begin
            code = wsd_pkg::LEN_CODE_64;
        end else if (pick >= 90) begin
            code = wsd_pkg::LEN_CODE_16;
        end else begin
            code = 7'(len);
        end
        send_byte(first_byte);
        send_byte({use_mask, code});
        if (code == wsd_pkg::LEN_CODE_64) begin
            repeat (6) send_byte(8'h00);
        end
        if (code == wsd_pkg::LEN_CODE_16 || code == wsd_pkg::LEN_CODE_64) begin
            send_byte(8'(len >> 8));
            send_byte(8'(len));
        end
        if (use_mask) begin
            repeat (4) send_byte(8'($urandom));
        end
        repeat (len) send_byte(8'($urandom));
    endtask

    // Hand-built frames: payload extremes, a masked frame with reserved bits
    // set, zero-length frames masked and not, and a non-minimal 64-bit length.
    task automatic test_directed_frames();
        // FIN set, text opcode, three unmasked bytes.
        send_byte(8'h81);
        send_byte(8'h03);
        send_byte(8'h61);
        send_byte(8'h00);
        send_byte(8'hFF);
        // FIN clear, all reserved bits set, opcode 15, masked, two bytes.
        send_byte(8'h7F);
        send_byte(8'h82);
        send_byte(8'hA5);
        send_byte(8'h3C);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h00);
        // Close frame with no payload: the marker comes on the length byte.
        send_byte(8'h88);
        send_byte(8'h00);
        // Masked 16-bit length of zero: the marker comes on the last key byte.
        send_byte(8'h02);
        send_byte(8'hFE);
        send_byte(8'h00);
        send_byte(8'h00);
        repeat (4) send_byte(8'($urandom));
        // 64-bit length of one, unmasked.
        send_byte(8'h80);
        send_byte(8'h7F);
        repeat (7) send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h5A);
    endtask

    // The bulk of the run. Idling is switched per frame so that some stretches
    // run at full rate, and every dozen frames the sender waits for the output.
    task automatic test_random_frames();
        int unsigned start_count;
        int unsigned frame_count;
        start_count = bytes_sent;
        frame_count = 0;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            idling_on = ($urandom_range(0, 4) != 0);
            send_random_frame();
            frame_count++;
            if (frame_count % 12 == 0) begin
                wait_until_drained();
            end
        end
        idling_on = 1'b1;
    endtask

    // Full-rate stream with neither side idling.
    task automatic test_full_rate_frames();
        idling_on = 1'b0;
        repeat (6) send_random_frame();
    endtask

    // A masked frame whose 64-bit length has its top bit set. It can never
    // finish, so it runs last and only a few payload bytes are sent.
    task automatic test_top_bit_length();
        send_byte(8'h81);
        send_byte(8'hFF);
        send_byte(8'h80);
        repeat (7) send_byte(8'h00);
        repeat (4) send_byte(8'($urandom));
        repeat (5) send_byte(8'($urandom));
    endtask

    // The receiver stalls in random bursts while idling is on.
    initial begin : stall_driver
        int unsigned burst;
        forever begin
            @(posedge i_clk);
            if (idling_on && i_rst_n && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 17);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Every transaction taken from the output is held against the oldest
    // expectation, field by field.
    initial begin : result_checker
        wsd_pkg::t_result want;
        logic             bad;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display({"unexpected transaction: ",
                                  "byte %h has %b fin %b op %h mask %b last %b"},
                                 o_payload_byte, o_has_byte, o_fin_flag, o_frame_opcode,
                                 o_was_masked, o_last_of_frame);
                    end
                end else begin
                    want = expected_results.pop_front();
                    bad = (o_payload_byte  !== want.payload_byte)
                       || (o_has_byte      !== want.has_byte)
                       || (o_fin_flag      !== want.fin_flag)
                       || (o_frame_opcode  !== want.frame_opcode)
                       || (o_was_masked    !== want.was_masked)
                       || (o_last_of_frame !== want.last_of_frame);
                    if (bad) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display({"mismatch: expected ",
                                      "byte %h has %b fin %b op %h mask %b last %b"},
                                     want.payload_byte, want.has_byte, want.fin_flag,
                                     want.frame_opcode, want.was_masked, want.last_of_frame);
                            $display({"          actual   ",
                                      "byte %h has %b fin %b op %h mask %b last %b"},
                                     o_payload_byte, o_has_byte, o_fin_flag, o_frame_opcode,
                                     o_was_masked, o_last_of_frame);
                        end
                    end
                end
            end
        end
    end

    // Hard stop in case the output never delivers.
    initial begin
        #4_000_000;
        $display("tb_websocket_frame_deframer_core: errors");
        $finish;
    end

    // Reset once, run the tests in order, then let the pipeline settle.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        test_random_frames();
        test_full_rate_frames();
        test_top_bit_length();
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_websocket_frame_deframer_core: clean");
        end else begin
            $display("tb_websocket_frame_deframer_core: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
